// ----- hw/rtl/b2da_pkg.sv -----
// Shared types and constants for the binary to decimal ASCII converter.
`default_nettype none
package b2da_pkg;

   // Bits in one packed decimal digit
   localparam int unsigned DIGIT_BITS = 4;
   // Width of one ASCII digit code on the result channel
   localparam int unsigned CHAR_BITS  = 6;
   // Result tdata width, digit code padded to a whole byte
   localparam int unsigned RSP_BITS   = 8;
   // ASCII code of '0'
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 6'd48;

   // Datapath commands issued by the controller
   typedef struct packed {
      logic load;       // capture a new value, clear the digit register
      logic step;       // one shift-add-3 conversion step
      logic shift_out;  // drop the top digit, advance to the next one
   } cmd_type;

   // Datapath status seen by the controller
   typedef struct packed {
      logic conv_done;  // the current step is the final conversion step
      logic top_zero;   // the top digit is zero
      logic last_digit; // the top digit is the least significant one
   } status_type;

endpackage
`default_nettype wire

// ----- hw/rtl/b2da_ctrl.sv -----
// Controller state machine: sequences load, conversion, zero skip and digit send.
`default_nettype none
module b2da_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output b2da_pkg::cmd_type         cmd,
   input  wire b2da_pkg::status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SKIP = 4'b0100,
      ST_SEND = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Handshake outputs follow the state
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SEND);

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.step      = 1'b0;
      cmd.shift_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            if (status.conv_done) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, always keep the final digit
            if (status.top_zero && !status.last_digit) begin
               cmd.shift_out = 1'b1;
            end else begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_tready) begin
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.shift_out = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/b2da_datapath.sv -----
// Datapath: shift-add-3 binary to BCD conversion and digit shift-out.
`default_nettype none
module b2da_datapath #(
   parameter int unsigned VALUE_BITS = 32,
   parameter int unsigned NDIGITS    = 10
) (
   input  wire logic                             clock,
   input  wire logic [VALUE_BITS-1:0]            value,
   input  wire b2da_pkg::cmd_type                cmd,
   output b2da_pkg::status_type                  status,
   output logic [b2da_pkg::CHAR_BITS-1:0]        digit_char
);

   localparam int unsigned BCD_BITS = NDIGITS * b2da_pkg::DIGIT_BITS;
   localparam int unsigned CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int unsigned DIG_BITS = (NDIGITS > 1) ? $clog2(NDIGITS) : 1;

   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]   bcd_adj;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [DIG_BITS-1:0]   dig_ff, dig_in;
   logic [b2da_pkg::DIGIT_BITS-1:0] top_digit;

   // Add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NDIGITS; i++) begin
         if (bcd_ff[i*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS] >= 4'd5) begin
            bcd_adj[i*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS] =
               bcd_ff[i*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS] + 4'd3;
         end else begin
            bcd_adj[i*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS] =
               bcd_ff[i*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS];
         end
      end
   end

   // Next values of the binary, digit and counter registers
   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      dig_in = dig_ff;
      if (cmd.load) begin
         bin_in = value;
         bcd_in = '0;
         cnt_in = CNT_BITS'(VALUE_BITS - 1);
         dig_in = DIG_BITS'(NDIGITS - 1);
      end else if (cmd.step) begin
         bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
         cnt_in = cnt_ff - 1'b1;
      end else if (cmd.shift_out) begin
         bcd_in = {bcd_ff[BCD_BITS-b2da_pkg::DIGIT_BITS-1:0],
                   {b2da_pkg::DIGIT_BITS{1'b0}}};
         dig_in = dig_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      dig_ff <= dig_in;
   end

   // Status and the ASCII code of the top digit
   assign top_digit         = bcd_ff[BCD_BITS-1 -: b2da_pkg::DIGIT_BITS];
   assign status.conv_done  = (cnt_ff == '0);
   assign status.top_zero   = (top_digit == '0);
   assign status.last_digit = (dig_ff == '0);
   assign digit_char = b2da_pkg::CHAR_ZERO |
      {{(b2da_pkg::CHAR_BITS-b2da_pkg::DIGIT_BITS){1'b0}}, top_digit};

endmodule
`default_nettype wire

// ----- hw/rtl/binary_to_decimal_ascii.sv -----
// Top level of the unsigned binary to decimal ASCII converter.
`default_nettype none
// Converts one unsigned VALUE_BITS-bit number per input beat into its decimal
// text, one ASCII digit ('0'..'9') per output beat, most significant first,
// leading zeros dropped (zero gives a single '0'), tlast on the final digit.
// One number is handled at a time: a load, the shift-add-3 steps in the BCD
// converter (one per value bit), the leading zeros dropped one by one, a step
// to start sending, then the digits sent one by one, each waiting while the
// output is held off. Dropped zeros and sent digits always add up to NDIGITS.
// NDIGITS is 10 for 32 bits, 20 for 64 bits.
module binary_to_decimal_ascii #(
   parameter int unsigned VALUE_BITS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [VALUE_BITS-1:0] value, zero padded to whole bytes
   input  wire logic [((VALUE_BITS+7)/8)*8-1:0]  req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [5:0] digit_char, [7:6] zero
   output logic [b2da_pkg::RSP_BITS-1:0]         rsp_tdata,
   output logic                                  rsp_tlast
);

   // Decimal digits of the largest value
   localparam int unsigned NDIGITS = ((VALUE_BITS * 1233) / 4096) + 1;

   b2da_pkg::cmd_type    cmd;
   b2da_pkg::status_type status;
   logic [b2da_pkg::CHAR_BITS-1:0] digit_char;

   b2da_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   b2da_datapath #(
      .VALUE_BITS (VALUE_BITS),
      .NDIGITS    (NDIGITS)
   ) u_datapath (
      .clock      (clock),
      .value      (req_tdata[VALUE_BITS-1:0]),
      .cmd        (cmd),
      .status     (status),
      .digit_char (digit_char)
   );

   // Pack the result beat
   assign rsp_tdata = {{(b2da_pkg::RSP_BITS-b2da_pkg::CHAR_BITS){1'b0}}, digit_char};
   assign rsp_tlast = status.last_digit;

endmodule
`default_nettype wire
